>>> hw/rtl/rmj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_pkg
// Shared widths, reset values and request types of the radar Jacobian block.
// ----------------------------------------------------------------------------
package rmj_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FLOOR_W       = 17;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 17'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_dpx;
    logic signed [DATA_W-1:0] range_dpy;
    logic signed [DATA_W-1:0] bearing_dpx;
    logic signed [DATA_W-1:0] bearing_dpy;
    logic signed [DATA_W-1:0] rate_dpx;
    logic signed [DATA_W-1:0] rate_dpy;
    logic                     near_origin;
    logic                     saturated;
  } out_item_t;

endpackage

>>> hw/rtl/rmj_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_sqrt_pipe
// Integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module rmj_sqrt_pipe #(
  parameter int W = rmj_pkg::DATA_W
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*W-1:0] v,
  output logic [W-1:0]   root
);

  localparam int RW = W + 2;

  logic [RW-1:0]  rem_r  [W];
  logic [W-1:0]   root_r [W];
  logic [2*W-1:0] rest_r [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [RW-1:0]  rem_p;
    logic [W-1:0]   root_p;
    logic [2*W-1:0] rest_p;
    logic [RW-1:0]  t;
    logic [RW-1:0]  trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rest_p = v;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rest_p = rest_r[k-1];
    end

    // bring down the next two bits of the radicand
    assign t     = {rem_p[RW-3:0], rest_p[2*W-1:2*W-2]};
    assign trial = {root_p, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (t - trial) : t;
        root_r[k] <= {root_p[W-2:0], ge};
        rest_r[k] <= {rest_p[2*W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[W-1];

endmodule

>>> hw/rtl/rmj_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_div_pipe
// Restoring divider, Q_W quotient bits, one bit per stage.
// ovf flags a quotient that does not fit in Q_W bits.
// ----------------------------------------------------------------------------
module rmj_div_pipe #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32,
  parameter int Q_W   = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);

  localparam int HI_W = NUM_W - Q_W;
  localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [DEN_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   low_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W+1];
  logic             ovf_r [Q_W+1];

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;

  assign hi_ext  = CW'(num[NUM_W-1:Q_W]);
  assign den_ext = CW'(den);

  // upper part at or above the divisor means the quotient needs more than Q_W bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_ext[DEN_W-1:0];
      den_r[0] <= den;
      low_r[0] <= num[Q_W-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= (hi_ext >= den_ext);
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [DEN_W:0] t;
    logic           ge;

    assign t    = {rem_r[k-1], low_r[k-1][Q_W-1]};
    assign ge   = (t >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= {q_r[k-1][Q_W-2:0], ge};
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    if (k < Q_W) begin : g_carry
      logic [DEN_W:0] diff;

      assign diff = t - {1'b0, den_r[k-1]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
          den_r[k] <= den_r[k-1];
          low_r[k] <= {low_r[k-1][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_r[Q_W];
  assign ovf = ovf_r[Q_W];

endmodule

>>> hw/rtl/radar_measurement_jacobian_top.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle; the whole pipe advances together and
// holds while a finished result is not taken.
// Depth is set by the bit-per-stage square root and the bit-per-stage dividers.
// Reset (synchronous, rst_n low) empties the pipe and loads the floor with 7.
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_top
// Radar measurement Jacobian entries from a Q16.16 state vector.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian_top #(
  parameter int FRAC_BITS = rmj_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rmj_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rmj_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [rmj_pkg::FLOOR_W-1:0]   cfg_wdata
);

  localparam int W      = rmj_pkg::DATA_W;
  localparam int FW     = rmj_pkg::FLOOR_W;
  localparam int SQ_LAT = W;
  localparam int DV_LAT = W + 1;
  localparam int LAT    = 2 * W + 8;

  typedef struct packed {
    logic [W-1:0]   pxm;
    logic [W-1:0]   pym;
    logic [2*W-1:0] r2;
    logic [2*W-1:0] dm;
    logic           nx;
    logic           ny;
    logic           nd;
    logic           near;
  } side_t;

  typedef struct packed {
    logic nx;
    logic ny;
    logic nd;
    logic near;
  } flags_t;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // {sat, value}: apply sign and clamp to the signed range
  function automatic logic [W:0] finish(input logic [W-1:0] q, input logic ovf,
                                        input logic neg);
    logic [W-1:0] lim;
    logic [W-1:0] mag;
    logic         sat;
    lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    sat = ovf || (q > lim);
    mag = sat ? lim : q;
    return {sat, neg ? (~mag + 1'b1) : mag};
  endfunction

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [FW-1:0]  floor_r;

  assign out_valid = vld_r[LAT-1];
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      floor_r <= rmj_pkg::FLOOR_RESET;
    end else begin
      if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
      if (cfg_we) floor_r <= cfg_wdata;
    end
  end

  // stage 1: request register
  rmj_pkg::in_item_t in_r;
  always_ff @(posedge clk) begin
    if (en) in_r <= in_item;
  end

  // stage 2: sign-magnitude split
  logic [W-1:0] px2_r, py2_r, vx2_r, vy2_r;
  logic         nx2_r, ny2_r, nvx2_r, nvy2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      px2_r  <= mag_of(in_r.pos_x);
      py2_r  <= mag_of(in_r.pos_y);
      vx2_r  <= mag_of(in_r.vel_x);
      vy2_r  <= mag_of(in_r.vel_y);
      nx2_r  <= in_r.pos_x[W-1];
      ny2_r  <= in_r.pos_y[W-1];
      nvx2_r <= in_r.vel_x[W-1];
      nvy2_r <= in_r.vel_y[W-1];
    end
  end

  // stage 3: squares and cross products
  logic [2*W-1:0] pxx3_r, pyy3_r, ma3_r, mb3_r;
  logic [W-1:0]   px3_r, py3_r;
  logic           nx3_r, ny3_r, na3_r, nb3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pxx3_r <= px2_r * px2_r;
      pyy3_r <= py2_r * py2_r;
      ma3_r  <= vx2_r * py2_r;
      mb3_r  <= vy2_r * px2_r;
      px3_r  <= px2_r;
      py3_r  <= py2_r;
      nx3_r  <= nx2_r;
      ny3_r  <= ny2_r;
      na3_r  <= nvx2_r ^ ny2_r;
      nb3_r  <= ~(nvy2_r ^ nx2_r);
    end
  end

  // stage 4: range squared with floor, D = vx*py - vy*px
  logic [FW-1:0]  floor_v;
  logic [2*W-1:0] thr, sum4, dm4;
  logic           near4, nd4;
  side_t          st4_r;

  assign floor_v = (floor_r == '0) ? FW'(1) : floor_r;
  assign thr     = (2*W)'(floor_v) << FRAC_BITS;
  assign sum4    = pxx3_r + pyy3_r;
  assign near4   = (sum4 < thr);

  always_comb begin
    if (na3_r == nb3_r) begin
      dm4 = ma3_r + mb3_r;
      nd4 = na3_r;
    end else if (ma3_r >= mb3_r) begin
      dm4 = ma3_r - mb3_r;
      nd4 = na3_r;
    end else begin
      dm4 = mb3_r - ma3_r;
      nd4 = nb3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st4_r.pxm  <= px3_r;
      st4_r.pym  <= py3_r;
      st4_r.r2   <= near4 ? thr : sum4;
      st4_r.dm   <= dm4;
      st4_r.nx   <= nx3_r;
      st4_r.ny   <= ny3_r;
      st4_r.nd   <= nd4;
      st4_r.near <= near4;
    end
  end

  // square root with the rest of the request alongside
  logic [W-1:0] root;
  side_t        sq_side_r [SQ_LAT];

  rmj_sqrt_pipe #(.W(W)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .v    (st4_r.r2),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r[0] <= st4_r;
      for (int i = 1; i < SQ_LAT; i++) sq_side_r[i] <= sq_side_r[i-1];
    end
  end

  // M1: half-width partial products of py*D, px*D and r2*s
  side_t          m1_r;
  logic [W-1:0]   s1_r;
  logic [2*W-1:0] pyd_lo_r, pyd_hi_r, pxd_lo_r, pxd_hi_r, rs_lo_r, rs_hi_r;
  side_t          sq_out;
  assign sq_out = sq_side_r[SQ_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r     <= sq_out;
      s1_r     <= root;
      pyd_lo_r <= sq_out.pym * sq_out.dm[W-1:0];
      pyd_hi_r <= sq_out.pym * sq_out.dm[2*W-1:W];
      pxd_lo_r <= sq_out.pxm * sq_out.dm[W-1:0];
      pxd_hi_r <= sq_out.pxm * sq_out.dm[2*W-1:W];
      rs_lo_r  <= root * sq_out.r2[W-1:0];
      rs_hi_r  <= root * sq_out.r2[2*W-1:W];
    end
  end

  // M2: recombine
  logic [W-1:0]   px_m2_r, py_m2_r, s2_r;
  logic [2*W-1:0] r2_m2_r;
  logic [3*W-1:0] pyd2_r, pxd2_r, rs2_r;
  flags_t         fl2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_m2_r <= m1_r.pxm;
      py_m2_r <= m1_r.pym;
      s2_r    <= s1_r;
      r2_m2_r <= m1_r.r2;
      pyd2_r  <= {pyd_hi_r, {W{1'b0}}} + (3*W)'(pyd_lo_r);
      pxd2_r  <= {pxd_hi_r, {W{1'b0}}} + (3*W)'(pxd_lo_r);
      rs2_r   <= {rs_hi_r, {W{1'b0}}} + (3*W)'(rs_lo_r);
      fl2_r   <= '{nx: m1_r.nx, ny: m1_r.ny, nd: m1_r.nd, near: m1_r.near};
    end
  end

  // six dividers in lockstep
  logic [W-1:0] q0, q1, q2, q3, q4, q5;
  logic         o0, o1, o2, o3, o4, o5;

  rmj_div_pipe #(.NUM_W(W+FRAC_BITS), .DEN_W(W), .Q_W(W)) u_div_rx (
    .clk(clk), .en(en), .num({px_m2_r, {FRAC_BITS{1'b0}}}), .den(s2_r),
    .quo(q0), .ovf(o0));
  rmj_div_pipe #(.NUM_W(W+FRAC_BITS), .DEN_W(W), .Q_W(W)) u_div_ry (
    .clk(clk), .en(en), .num({py_m2_r, {FRAC_BITS{1'b0}}}), .den(s2_r),
    .quo(q1), .ovf(o1));
  rmj_div_pipe #(.NUM_W(W+2*FRAC_BITS), .DEN_W(2*W), .Q_W(W)) u_div_bx (
    .clk(clk), .en(en), .num({py_m2_r, {(2*FRAC_BITS){1'b0}}}), .den(r2_m2_r),
    .quo(q2), .ovf(o2));
  rmj_div_pipe #(.NUM_W(W+2*FRAC_BITS), .DEN_W(2*W), .Q_W(W)) u_div_by (
    .clk(clk), .en(en), .num({px_m2_r, {(2*FRAC_BITS){1'b0}}}), .den(r2_m2_r),
    .quo(q3), .ovf(o3));
  rmj_div_pipe #(.NUM_W(3*W+FRAC_BITS), .DEN_W(3*W), .Q_W(W)) u_div_vx (
    .clk(clk), .en(en), .num({pyd2_r, {FRAC_BITS{1'b0}}}), .den(rs2_r),
    .quo(q4), .ovf(o4));
  rmj_div_pipe #(.NUM_W(3*W+FRAC_BITS), .DEN_W(3*W), .Q_W(W)) u_div_vy (
    .clk(clk), .en(en), .num({pxd2_r, {FRAC_BITS{1'b0}}}), .den(rs2_r),
    .quo(q5), .ovf(o5));

  flags_t dv_fl_r [DV_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      dv_fl_r[0] <= fl2_r;
      for (int i = 1; i < DV_LAT; i++) dv_fl_r[i] <= dv_fl_r[i-1];
    end
  end

  // final stage: signs, saturation, output register
  flags_t fl;
  logic [W:0] f0, f1, f2, f3, f4, f5;
  assign fl = dv_fl_r[DV_LAT-1];
  assign f0 = finish(q0, o0, fl.nx);
  assign f1 = finish(q1, o1, fl.ny);
  assign f2 = finish(q2, o2, !fl.ny);
  assign f3 = finish(q3, o3, fl.nx);
  assign f4 = finish(q4, o4, fl.ny ^ fl.nd);
  assign f5 = finish(q5, o5, !(fl.nx ^ fl.nd));

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.range_dpx   <= f0[W-1:0];
      out_item.range_dpy   <= f1[W-1:0];
      out_item.bearing_dpx <= f2[W-1:0];
      out_item.bearing_dpy <= f3[W-1:0];
      out_item.rate_dpx    <= f4[W-1:0];
      out_item.rate_dpy    <= f5[W-1:0];
      out_item.near_origin <= fl.near;
      out_item.saturated   <= f0[W] | f1[W] | f2[W] | f3[W] | f4[W] | f5[W];
    end
  end

  // a held result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while result stalled");

  // an accepted request enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted request lost at entry");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
